// ===== sv/sirc_pkg.sv =====
// shared types and constants for the sirc frame sequencer
// beat structs, action and format codes, register map and reset values
// no dependencies
`default_nettype none

package sirc_pkg;

  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned ELAPSED_W   = 21;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_START_MARK  = 3'd0,
    REG_ONE_MARK    = 3'd1,
    REG_ZERO_MARK   = 3'd2,
    REG_SPACE       = 3'd3,
    REG_REPEAT_PER  = 3'd4,
    REG_REPEAT_LIM  = 3'd5
  } reg_index_t;

  localparam logic [15:0] START_MARK_RST  = 16'd2400;
  localparam logic [15:0] ONE_MARK_RST    = 16'd1200;
  localparam logic [15:0] ZERO_MARK_RST   = 16'd600;
  localparam logic [15:0] SPACE_RST       = 16'd600;
  localparam logic [15:0] REPEAT_PER_RST  = 16'd45000;
  localparam logic [3:0]  REPEAT_LIM_RST  = 4'd4;

  localparam logic [3:0]  PACKETS_MAX     = 4'd15;
  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = {ELAPSED_W{1'b1}};

  localparam int unsigned FRAME_LEN_12 = 12;
  localparam int unsigned FRAME_LEN_15 = 15;
  localparam int unsigned FRAME_LEN_20 = 20;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  localparam logic [1:0] FMT_12       = 2'd0;
  localparam logic [1:0] FMT_15       = 2'd1;
  localparam logic [1:0] FMT_20       = 2'd2;
  localparam logic [1:0] FMT_RESERVED = 2'd3;

  typedef enum logic [2:0] {
    ACT_IGNORED  = 3'd0,
    ACT_STARTED  = 3'd1,
    ACT_BIT_MARK = 3'd2,
    ACT_GAP      = 3'd3,
    ACT_FINISHED = 3'd4
  } action_t;

  typedef struct packed {
    logic       command;
    logic [6:0] key_code;
    logic [7:0] ir_address;
    logic [7:0] extended_byte;
    logic [1:0] frame_format;
  } in_beat_t;

  typedef struct packed {
    action_t     action;
    logic [15:0] mark_period;
    logic        extended_space;
    logic        busy_res;
  } out_beat_t;

  typedef struct packed {
    logic [15:0] start_mark_time;
    logic [15:0] one_mark_time;
    logic [15:0] zero_mark_time;
    logic [15:0] space_time;
    logic [15:0] repeat_period;
    logic [3:0]  repeat_limit;
  } cfg_regs_t;

endpackage

`default_nettype wire

// ===== sv/sirc_ir_frame_sequencer_unit.sv =====
// Infrared remote frame sequencer, 12-, 15- and 20-bit frames. A start beat
// loads the frame and answers with the start mark time; each later tick beat
// answers with the next timer setting (bit mark, end-of-packet gap, finish);
// idle ticks and reserved-format starts are ignored. Every input beat yields
// exactly one result beat, and one beat is accepted every clock cycle while
// in_stall is low; the result register plus a one-entry skid buffer keep
// input flowing while a result waits on out_stall, and in_stall rises only
// once both are full. Configuration writes through cfg_wr_en/cfg_index/cfg_wdata
// are meant for idle periods only. Depends on sirc_pkg and sirc_seq_core.
`default_nettype none

module sirc_ir_frame_sequencer_unit
  import sirc_pkg::*;
#(
  parameter int unsigned MAX_FRAME_BITS = 20
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire in_beat_t               in_data,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output out_beat_t                   out_data,
  input  wire logic                   cfg_wr_en,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_wdata
);

  cfg_regs_t cfg_r;
  out_beat_t res;
  out_beat_t out_r;
  out_beat_t skid_r;
  logic      out_valid_r;
  logic      skid_valid_r;
  logic      in_acc;
  logic      out_take;

  assign in_acc   = in_valid && !skid_valid_r;
  assign out_take = out_valid_r && !out_stall;
  assign in_stall  = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // config register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{start_mark_time: START_MARK_RST, one_mark_time: ONE_MARK_RST,
                 zero_mark_time: ZERO_MARK_RST, space_time: SPACE_RST,
                 repeat_period: REPEAT_PER_RST, repeat_limit: REPEAT_LIM_RST};
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_START_MARK: cfg_r.start_mark_time <= cfg_wdata;
        REG_ONE_MARK:   cfg_r.one_mark_time   <= cfg_wdata;
        REG_ZERO_MARK:  cfg_r.zero_mark_time  <= cfg_wdata;
        REG_SPACE:      cfg_r.space_time      <= cfg_wdata;
        REG_REPEAT_PER: cfg_r.repeat_period   <= cfg_wdata;
        REG_REPEAT_LIM: cfg_r.repeat_limit    <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  sirc_seq_core #(
    .MAX_FRAME_BITS(MAX_FRAME_BITS)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .acc   (in_acc),
    .beat  (in_data),
    .cfg   (cfg_r),
    .res   (res)
  );

  // result register with skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_take) begin
        skid_valid_r <= 1'b0;
      end
    end else if (out_take || !out_valid_r) begin
      out_valid_r <= in_acc;
    end else if (in_acc) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_take) out_r <= skid_r;
    end else if (out_take || !out_valid_r) begin
      if (in_acc) out_r <= res;
    end else if (in_acc) begin
      skid_r <= res;
    end
  end

`ifndef SYNTHESIS
  a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held without a pending result");

  a_finish_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.action == ACT_FINISHED) |->
      (!out_r.busy_res && out_r.mark_period == 16'd0))
    else $error("finish result still busy or carries a period");

  a_gap_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.extended_space == (out_r.action == ACT_GAP)))
    else $error("extended space flag does not match gap action");
`endif

endmodule

`default_nettype wire

// ===== sv/sirc_seq_core.sv =====
// frame sequencer state and per-beat update logic
// holds frame word, shift register, counters; one result per accepted beat
// depends on sirc_pkg
`default_nettype none

module sirc_seq_core
  import sirc_pkg::*;
#(
  parameter int unsigned MAX_FRAME_BITS = 20
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      acc,
  input  wire in_beat_t  beat,
  input  wire cfg_regs_t cfg,
  output out_beat_t      res
);

  localparam int unsigned PW = (MAX_FRAME_BITS < FRAME_LEN_20) ? MAX_FRAME_BITS : FRAME_LEN_20;
  localparam logic [4:0] LEN12 = 5'(FRAME_LEN_12);
  localparam logic [4:0] LEN15 =
    (MAX_FRAME_BITS < FRAME_LEN_15) ? 5'(MAX_FRAME_BITS) : 5'(FRAME_LEN_15);
  localparam logic [4:0] LEN20 =
    (MAX_FRAME_BITS < FRAME_LEN_20) ? 5'(MAX_FRAME_BITS) : 5'(FRAME_LEN_20);

  logic [PW-1:0]        held_r, held_nxt;
  logic [PW-1:0]        shift_r, shift_nxt;
  logic [4:0]           len_r, len_nxt;
  logic [4:0]           bit_r, bit_nxt;
  logic [3:0]           packets_r, packets_nxt;
  logic [ELAPSED_W-1:0] elapsed_r, elapsed_nxt;
  logic                 active_r, active_nxt;

  logic [19:0]          word;
  logic [PW-1:0]        sh;
  logic [ELAPSED_W-1:0] el;
  logic                 finish;
  logic [15:0]          mark;
  logic [ELAPSED_W:0]   esum;
  logic [22:0]          gap;

  assign word = {beat.extended_byte & {8{beat.frame_format == FMT_20}}, 12'd0}
              | {5'd0, beat.ir_address, 7'd0}
              | {13'd0, beat.key_code};

  always_comb begin
    held_nxt    = held_r;
    shift_nxt   = shift_r;
    len_nxt     = len_r;
    bit_nxt     = bit_r;
    packets_nxt = packets_r;
    elapsed_nxt = elapsed_r;
    active_nxt  = active_r;
    sh          = shift_r;
    el          = elapsed_r;
    finish      = 1'b0;
    mark        = '0;
    esum        = '0;
    gap         = '0;
    res         = '{action: ACT_IGNORED, mark_period: 16'd0, extended_space: 1'b0,
                    busy_res: active_r};
    if (beat.command == CMD_START) begin
      if (beat.frame_format != FMT_RESERVED) begin
        held_nxt = word[PW-1:0];
        case (beat.frame_format)
          FMT_15:  len_nxt = LEN15;
          FMT_20:  len_nxt = LEN20;
          default: len_nxt = LEN12;
        endcase
        shift_nxt   = '0;
        bit_nxt     = '0;
        packets_nxt = '0;
        elapsed_nxt = '0;
        active_nxt  = 1'b1;
        res = '{action: ACT_STARTED, mark_period: cfg.start_mark_time,
                extended_space: 1'b0, busy_res: 1'b1};
      end
    end else if (!active_r) begin
      res.busy_res = 1'b0;
    end else begin
      if (bit_r == 5'd0) begin
        if (packets_r != PACKETS_MAX) packets_nxt = packets_r + 4'd1;
        if (packets_r >= cfg.repeat_limit) begin
          finish     = 1'b1;
          active_nxt = 1'b0;
          res = '{action: ACT_FINISHED, mark_period: 16'd0, extended_space: 1'b0,
                  busy_res: 1'b0};
        end else begin
          sh = held_r;
          el = '0;
        end
      end
      if (!finish) begin
        if (bit_r < len_r) begin
          mark = sh[0] ? cfg.one_mark_time : cfg.zero_mark_time;
          esum = {1'b0, el} + (ELAPSED_W+1)'(mark) + (ELAPSED_W+1)'(cfg.space_time);
          elapsed_nxt = esum[ELAPSED_W] ? ELAPSED_MAX : esum[ELAPSED_W-1:0];
          bit_nxt     = bit_r + 5'd1;
          shift_nxt   = sh >> 1;
          res = '{action: ACT_BIT_MARK, mark_period: mark, extended_space: 1'b0,
                  busy_res: 1'b1};
        end else begin
          gap = {7'd0, cfg.repeat_period} - {7'd0, cfg.space_time} - {2'd0, el};
          shift_nxt   = sh;
          elapsed_nxt = el;
          bit_nxt     = '0;
          res = '{action: ACT_GAP, mark_period: gap[22] ? 16'd0 : gap[15:0],
                  extended_space: 1'b1, busy_res: 1'b1};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r    <= '0;
      shift_r   <= '0;
      len_r     <= '0;
      bit_r     <= '0;
      packets_r <= '0;
      elapsed_r <= '0;
      active_r  <= 1'b0;
    end else if (acc) begin
      held_r    <= held_nxt;
      shift_r   <= shift_nxt;
      len_r     <= len_nxt;
      bit_r     <= bit_nxt;
      packets_r <= packets_nxt;
      elapsed_r <= elapsed_nxt;
      active_r  <= active_nxt;
    end
  end

endmodule

`default_nettype wire
